// File: src/ccfd_pkg.sv
`timescale 1ns / 1ps

package ccfd_pkg;

  // Frame size limit and field limits
  localparam int unsigned MaxFrameBytes = 2048;
  localparam int unsigned LenFieldMax   = 4095;
  localparam logic [7:0]  MinLenReset   = 8'd8;
  localparam logic [7:0]  CobsCodeMax   = 8'hFF;

  // CRC-32, IEEE reflected form
  localparam logic [31:0] CrcPoly    = 32'hEDB88320;
  localparam logic [31:0] CrcInit    = 32'hFFFFFFFF;
  localparam logic [31:0] CrcResidue = 32'h2144DF1C;

  typedef enum logic [2:0] {
    StOk       = 3'd0,
    StCobs     = 3'd1,
    StShort    = 3'd2,
    StCrc      = 3'd3,
    StOverflow = 3'd4
  } status_e;

  // Per-frame decoder state (the byte counter lives beside it, sized by parameter)
  typedef struct packed {
    logic [7:0]  block_total;
    logic [7:0]  block_count;
    logic [31:0] crc;
    logic        overflowed;
  } cobs_state_t;

  localparam cobs_state_t StateReset = '{
    block_total: CobsCodeMax,
    block_count: CobsCodeMax,
    crc:         CrcInit,
    overflowed:  1'b0
  };

  typedef struct packed {
    logic        valid;
    logic        is_frame_end;
    logic [7:0]  data;
    status_e     status;
    logic [11:0] length;
  } result_t;

  // One byte through the reflected CRC-32, bit by bit
  function automatic logic [31:0] crc32_byte(input logic [31:0] crc_in,
                                             input logic [7:0]  data);
    logic [31:0] crc;
    crc = crc_in ^ {24'h000000, data};
    for (int k = 0; k < 8; k++) begin
      if (crc[0]) begin
        crc = (crc >> 1) ^ CrcPoly;
      end else begin
        crc = crc >> 1;
      end
    end
    return crc;
  endfunction

endpackage

// File: src/ccfd_decode.sv
`timescale 1ns / 1ps

module ccfd_decode #(
  parameter int unsigned MAX_FRAME_BYTES = ccfd_pkg::MaxFrameBytes,
  localparam int unsigned CntW = $clog2(MAX_FRAME_BYTES + 1)
) (
  input  logic [7:0]           rx_byte_i,
  input  logic [7:0]           min_len_i,
  input  ccfd_pkg::cobs_state_t state_i,
  input  logic [CntW-1:0]      count_i,
  output ccfd_pkg::cobs_state_t state_o,
  output logic [CntW-1:0]      count_o,
  output ccfd_pkg::result_t    result_o
);

  localparam int unsigned CmpW = (CntW > 12) ? CntW : 12;

  logic            take;
  logic [7:0]      take_byte;
  logic [CmpW-1:0] count_ext;

  assign count_ext = CmpW'(count_i);

  always_comb begin
    state_o               = state_i;
    count_o               = count_i;
    result_o.valid        = 1'b0;
    result_o.is_frame_end = 1'b0;
    result_o.data         = 8'h00;
    result_o.status       = ccfd_pkg::StOk;
    result_o.length       = 12'h000;
    take                  = 1'b0;
    take_byte             = 8'h00;

    if (rx_byte_i == 8'h00) begin
      // Delimiter: report and restart
      result_o.valid        = 1'b1;
      result_o.is_frame_end = 1'b1;
      if (state_i.overflowed) begin
        result_o.status = ccfd_pkg::StOverflow;
      end else if (state_i.block_count != state_i.block_total) begin
        result_o.status = ccfd_pkg::StCobs;
      end else if (count_ext < CmpW'(min_len_i)) begin
        result_o.status = ccfd_pkg::StShort;
      end else if (state_i.crc != ~ccfd_pkg::CrcResidue) begin
        result_o.status = ccfd_pkg::StCrc;
      end else begin
        result_o.status = ccfd_pkg::StOk;
      end
      if (count_ext > CmpW'(ccfd_pkg::LenFieldMax)) begin
        result_o.length = 12'(ccfd_pkg::LenFieldMax);
      end else begin
        result_o.length = count_ext[11:0];
      end
      state_o = ccfd_pkg::StateReset;
      count_o = '0;
    end else if (state_i.block_count == state_i.block_total) begin
      // Code byte: open a new block, insert the implied zero after a short block
      state_o.block_total = rx_byte_i;
      state_o.block_count = 8'd1;
      take                = (state_i.block_total != ccfd_pkg::CobsCodeMax);
      take_byte           = 8'h00;
    end else begin
      state_o.block_count = state_i.block_count + 8'd1;
      take                = 1'b1;
      take_byte           = rx_byte_i;
    end

    if (take) begin
      if (count_i >= CntW'(MAX_FRAME_BYTES)) begin
        // Past the size limit: drop the byte, flag the frame
        state_o.overflowed = 1'b1;
      end else begin
        count_o        = count_i + CntW'(1);
        state_o.crc    = ccfd_pkg::crc32_byte(state_i.crc, take_byte);
        result_o.valid = 1'b1;
        result_o.data  = take_byte;
      end
    end
  end

endmodule

// File: src/cobs_crc_frame_decoder_core.sv
// COBS frame decoder with CRC-32 check. Received link bytes enter on rx_byte_i; a zero byte
// closes the frame and every other byte is COBS-decoded, each decoded byte leaving as a data
// transaction (is_frame_end_o low) as soon as it is known. A reflected CRC-32 (IEEE,
// polynomial 0xEDB88320, preset all ones) runs over the decoded bytes. The delimiter yields
// one status transaction (is_frame_end_o high) carrying frame_status_o (0 ok, 1 COBS length
// error, 2 too short, 3 bad CRC residue, 4 overflow, checked in priority 4, 1, 2, 3) and
// frame_length_o (decoded bytes, saturating at MAX_FRAME_BYTES and at 4095); the decoder then
// restarts. Decoded bytes beyond MAX_FRAME_BYTES are dropped and the frame reports overflow.
// Code bytes produce no output unless they insert an implied zero. The register written on
// the cfg channel is min_frame_length (reset 8); write it only while the decoder is idle.
// Rate: one byte per clock while results are taken; a byte is registered in the input stage
// on acceptance, decoded and CRC'd by one unrolled byte step, and its result is loaded into
// the output register when that stage advances. A stalled result holds the input stage only
// when the waiting byte also produces a result. The CRC byte update and COBS block counter
// are combinational; there is no reset clearing pass.
`timescale 1ns / 1ps

module cobs_crc_frame_decoder_core #(
  parameter int unsigned MAX_FRAME_BYTES = ccfd_pkg::MaxFrameBytes
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration write channel (min_frame_length)
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [7:0]  cfg_data_i,
  // received byte stream
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  rx_byte_i,
  // decoded bytes and frame status
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        is_frame_end_o,
  output logic [7:0]  out_byte_o,
  output logic [2:0]  frame_status_o,
  output logic [11:0] frame_length_o
);

  localparam int unsigned CntW = $clog2(MAX_FRAME_BYTES + 1);

  // Configuration register
  logic [7:0] min_len_q;

  // Input stage
  logic       s1_valid_q;
  logic [7:0] s1_byte_q;
  logic       s1_fire;

  // Frame state
  ccfd_pkg::cobs_state_t state_q, state_d;
  logic [CntW-1:0]       count_q, count_d;
  ccfd_pkg::result_t     result;

  // Output register
  logic        out_valid_q, out_valid_d;
  logic        out_end_q;
  logic [7:0]  out_byte_q;
  logic [2:0]  out_status_q;
  logic [11:0] out_len_q;

  ccfd_decode #(
    .MAX_FRAME_BYTES(MAX_FRAME_BYTES)
  ) u_decode (
    .rx_byte_i (s1_byte_q),
    .min_len_i (min_len_q),
    .state_i   (state_q),
    .count_i   (count_q),
    .state_o   (state_d),
    .count_o   (count_d),
    .result_o  (result)
  );

  // Advance the input stage when its byte has no result, or the output register has room.
  assign s1_fire    = s1_valid_q && (!result.valid || !out_valid_q || out_ready_i);
  assign in_ready_o = !s1_valid_q || s1_fire;

  // Hold an unaccepted result; load a new one when the stage advances with one.
  always_comb begin
    out_valid_d = out_valid_q && !out_ready_i;
    if (s1_fire && result.valid) begin
      out_valid_d = 1'b1;
    end
  end

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_len_q   <= ccfd_pkg::MinLenReset;
      s1_valid_q  <= 1'b0;
      state_q     <= ccfd_pkg::StateReset;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        min_len_q <= cfg_data_i;
      end
      if (in_ready_o) begin
        s1_valid_q <= in_valid_i;
      end
      if (s1_fire) begin
        state_q <= state_d;
        count_q <= count_d;
      end
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers, no reset
  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      s1_byte_q <= rx_byte_i;
    end
    if (s1_fire && result.valid) begin
      out_end_q    <= result.is_frame_end;
      out_byte_q   <= result.data;
      out_status_q <= result.status;
      out_len_q    <= result.length;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign is_frame_end_o = out_end_q;
  assign out_byte_o     = out_byte_q;
  assign frame_status_o = out_status_q;
  assign frame_length_o = out_len_q;

endmodule

// File: src/ccfd_checker.sv
`timescale 1ns / 1ps

module ccfd_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        cfg_valid_i,
  input logic        cfg_ready_o,
  input logic [7:0]  cfg_data_i,
  input logic        in_valid_i,
  input logic        in_ready_o,
  input logic [7:0]  rx_byte_i,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic        is_frame_end_o,
  input logic [7:0]  out_byte_o,
  input logic [2:0]  frame_status_o,
  input logic [11:0] frame_length_o
);

  // A stalled output transaction stays offered with the same payload
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_byte_o)
      && $stable(is_frame_end_o) && $stable(frame_status_o) && $stable(frame_length_o))
    else $error("output transaction changed while stalled");

  // Data bytes carry no status and no length
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !is_frame_end_o |->
      frame_status_o == ccfd_pkg::StOk && frame_length_o == 12'h000)
    else $error("data transaction with status fields set");

  // Status transactions carry a zero byte
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && is_frame_end_o |-> out_byte_o == 8'h00)
    else $error("status transaction with nonzero byte");

  // An empty pipeline shows no output at the clock edge where reset is seen to release
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(rst_ni) |-> !out_valid_o)
    else $error("output valid straight out of reset");

endmodule

bind cobs_crc_frame_decoder_core ccfd_checker u_ccfd_checker (.*);

// File: sim/ccfd_frame_checker.sv
`timescale 1ns / 1ps

module ccfd_frame_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  input  logic        cfg_ready_i,
  input  logic [7:0]  cfg_data_i,
  input  logic        in_valid_i,
  input  logic        in_ready_i,
  input  logic [7:0]  rx_byte_i,
  input  logic        out_valid_i,
  input  logic        out_ready_i,
  input  logic        is_frame_end_i,
  input  logic [7:0]  out_byte_i,
  input  logic [2:0]  frame_status_i,
  input  logic [11:0] frame_length_i,
  output int unsigned fail_count_o,
  output int unsigned pending_o
);

  localparam logic [31:0] ReflPoly      = 32'hEDB88320;
  localparam logic [31:0] GoodResidue   = 32'h2144DF1C;
  localparam logic [7:0]  Delimiter     = 8'h00;
  localparam logic [7:0]  FullCode      = 8'hFF;
  localparam logic [7:0]  MinLenAtReset = 8'd8;
  localparam int unsigned FrameCap      = ccfd_pkg::MaxFrameBytes;
  localparam int unsigned LenSat        = 4095;

  typedef struct packed {
    logic              is_end;
    logic [7:0]        data;
    ccfd_pkg::status_e status;
    logic [11:0]       length;
  } link_result_t;

  link_result_t decoder_out_q[$];

  logic [7:0]  min_len;
  logic [7:0]  code_total;
  logic [7:0]  code_pos;
  logic [31:0] crc_acc;
  int unsigned decoded_cnt;
  logic        dropped;

  // Per-bit feedback form of the reflected CRC-32
  function automatic logic [31:0] crc_next(logic [31:0] c, logic [7:0] d);
    logic fb;
    for (int i = 0; i < 8; i++) begin
      fb = c[0] ^ d[i];
      c  = c >> 1;
      if (fb) c = c ^ ReflPoly;
    end
    return c;
  endfunction

  function automatic int field_diff(string name, int unsigned want, int unsigned seen);
    if (want != seen) begin
      $display("%0t ns: %s expected 0x%0h, got 0x%0h", $time, name, want, seen);
      return 1;
    end
    return 0;
  endfunction

  task automatic restart_frame();
    code_total  = FullCode;
    code_pos    = FullCode;
    crc_acc     = '1;
    decoded_cnt = 0;
    dropped     = 1'b0;
  endtask

  // Count and checksum one decoded byte, or drop it once the frame is full
  task automatic take_decoded(input logic [7:0] b);
    link_result_t r;
    r = '0;
    if (decoded_cnt >= FrameCap) begin
      dropped = 1'b1;
    end else begin
      decoded_cnt++;
      crc_acc = crc_next(crc_acc, b);
      r.data  = b;
      decoder_out_q.push_back(r);
    end
  endtask

  task automatic decode_link_byte(input logic [7:0] b);
    link_result_t r;
    logic         zero_due;
    r = '0;
    if (b == Delimiter) begin
      r.is_end = 1'b1;
      if (dropped) r.status = ccfd_pkg::StOverflow;
      else if (code_pos != code_total) r.status = ccfd_pkg::StCobs;
      else if (decoded_cnt < min_len) r.status = ccfd_pkg::StShort;
      else if (~crc_acc != GoodResidue) r.status = ccfd_pkg::StCrc;
      else r.status = ccfd_pkg::StOk;
      r.length = (decoded_cnt > LenSat) ? 12'(LenSat) : 12'(decoded_cnt);
      decoder_out_q.push_back(r);
      restart_frame();
    end else if (code_pos == code_total) begin
      zero_due   = (code_total != FullCode);
      code_total = b;
      code_pos   = 8'd1;
      if (zero_due) take_decoded(8'h00);
    end else begin
      code_pos = code_pos + 8'd1;
      take_decoded(b);
    end
  endtask

  task automatic compare_result();
    link_result_t want;
    if (decoder_out_q.size() == 0) begin
      $display("%0t ns: expected no result, got end=%0b byte=0x%0h status=%0d length=%0d",
               $time, is_frame_end_i, out_byte_i, frame_status_i, frame_length_i);
      fail_count_o++;
    end else begin
      want = decoder_out_q.pop_front();
      fail_count_o += field_diff("is_frame_end", want.is_end, is_frame_end_i);
      fail_count_o += field_diff("out_byte", want.data, out_byte_i);
      fail_count_o += field_diff("frame_status", want.status, frame_status_i);
      fail_count_o += field_diff("frame_length", want.length, frame_length_i);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_len = MinLenAtReset;
      restart_frame();
      decoder_out_q.delete();
      fail_count_o = 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) min_len = cfg_data_i;
      if (in_valid_i && in_ready_i) decode_link_byte(rx_byte_i);
      if (out_valid_i && out_ready_i) compare_result();
    end
    pending_o = decoder_out_q.size();
  end

endmodule

// File: sim/tb.sv
`timescale 1ns / 1ps

module tb;

  localparam int          HalfPeriodNs    = 5;
  localparam int          ResetCycles     = 8;
  localparam int unsigned StallLimit      = 2000;
  localparam int          DrainCycles     = 6;
  localparam int          PhaseBytes      = 350;
  localparam int          CfgSegmentBytes = 120;
  localparam logic [7:0]  Delimiter       = 8'h00;
  localparam logic [7:0]  EmptyCode       = 8'h01;
  localparam logic [7:0]  FullCode        = 8'hFF;
  localparam logic [31:0] ReflPoly        = 32'hEDB88320;

  logic        clk          = 1'b0;
  logic        rst_n        = 1'b0;
  logic        cfg_valid    = 1'b0;
  logic        cfg_ready;
  logic [7:0]  cfg_data     = '0;
  logic        in_valid     = 1'b0;
  logic        in_ready;
  logic [7:0]  rx_byte      = '0;
  logic        out_valid;
  logic        out_ready    = 1'b0;
  logic        is_frame_end;
  logic [7:0]  out_byte;
  logic [2:0]  frame_status;
  logic [11:0] frame_length;

  int unsigned fail_count;
  int unsigned pending;

  // Idle percentages per cycle on each side; changed by the stimulus per phase
  int          tx_idle_pct  = 0;
  int          rx_idle_pct  = 0;
  int unsigned link_bytes_sent = 0;
  int unsigned quiet_cycles = 0;

  logic [7:0]  raw_q[$];    // decoded frame content before COBS
  logic [7:0]  link_q[$];   // COBS-encoded bytes, delimiter not included

  always #(HalfPeriodNs) clk = ~clk;

  cobs_crc_frame_decoder_core i_dut (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .cfg_valid_i    (cfg_valid),
    .cfg_ready_o    (cfg_ready),
    .cfg_data_i     (cfg_data),
    .in_valid_i     (in_valid),
    .in_ready_o     (in_ready),
    .rx_byte_i      (rx_byte),
    .out_valid_o    (out_valid),
    .out_ready_i    (out_ready),
    .is_frame_end_o (is_frame_end),
    .out_byte_o     (out_byte),
    .frame_status_o (frame_status),
    .frame_length_o (frame_length)
  );

  ccfd_frame_checker i_check (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .cfg_valid_i    (cfg_valid),
    .cfg_ready_i    (cfg_ready),
    .cfg_data_i     (cfg_data),
    .in_valid_i     (in_valid),
    .in_ready_i     (in_ready),
    .rx_byte_i      (rx_byte),
    .out_valid_i    (out_valid),
    .out_ready_i    (out_ready),
    .is_frame_end_i (is_frame_end),
    .out_byte_i     (out_byte),
    .frame_status_i (frame_status),
    .frame_length_i (frame_length),
    .fail_count_o   (fail_count),
    .pending_o      (pending)
  );

  // Stall the result side at random, at the rate of the current phase
  always @(negedge clk) begin
    out_ready <= ($urandom_range(99) >= rx_idle_pct);
  end

  // Abort when no transaction moves on any channel for too long
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= StallLimit) begin
      $display("tb NOT OK");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  function automatic logic [31:0] crc_step(logic [31:0] c, logic [7:0] d);
    c = c ^ {24'd0, d};
    repeat (8) c = c[0] ? ((c >> 1) ^ ReflPoly) : (c >> 1);
    return c;
  endfunction

  // Zeros and the extremes weighted up, so implied zeros and long blocks both show up
  function automatic logic [7:0] pick_data_byte(int zero_pct);
    int r;
    r = $urandom_range(99);
    if (r < zero_pct) return 8'h00;
    if (r < zero_pct + 5) return 8'hFF;
    if (r < zero_pct + 10) return 8'h01;
    return 8'($urandom_range(255, 1));
  endfunction

  // First two settings are the extremes, then mostly small thresholds
  function automatic logic [7:0] pick_min_len(int idx);
    if (idx == 0) return 8'h00;
    if (idx == 1) return 8'hFF;
    if ($urandom_range(99) < 70) return 8'($urandom_range(16));
    return 8'($urandom_range(255));
  endfunction

  // Call at a falling edge; return at the falling edge after acceptance
  task automatic send_byte(input logic [7:0] b);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    rx_byte  <= b;
    do @(posedge clk); while (!in_ready);
    link_bytes_sent++;
    @(negedge clk);
  endtask

  // Send the encoded frame, then close it with a delimiter
  task automatic send_link();
    foreach (link_q[k]) send_byte(link_q[k]);
    send_byte(Delimiter);
  endtask

  // Hold the sender off until every result has come out, then let the pipe settle
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (DrainCycles) @(negedge clk);
  endtask

  task automatic write_min_len(input logic [7:0] v);
    wait_idle();
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic fill_payload(input int n, input int zero_pct);
    raw_q.delete();
    repeat (n) raw_q.push_back(pick_data_byte(zero_pct));
  endtask

  // Append the finalized CRC low byte first, so the frame checks to the residue
  task automatic append_crc();
    logic [31:0] c;
    c = '1;
    foreach (raw_q[k]) c = crc_step(c, raw_q[k]);
    c = ~c;
    for (int k = 0; k < 4; k++) raw_q.push_back(c[8*k +: 8]);
  endtask

  task automatic encode_link();
    int code_at;
    link_q  = {EmptyCode};
    code_at = 0;
    foreach (raw_q[k]) begin
      if (raw_q[k] == Delimiter) begin
        link_q.push_back(EmptyCode);
        code_at = link_q.size() - 1;
      end else begin
        link_q.push_back(raw_q[k]);
        link_q[code_at] = link_q[code_at] + 8'd1;
        // Close a full block; no zero is implied after it
        if (link_q[code_at] == FullCode) begin
          link_q.push_back(EmptyCode);
          code_at = link_q.size() - 1;
        end
      end
    end
  endtask

  // Mostly well-formed frames; the rest have a bad CRC, a broken COBS block,
  // are raw noise or are empty
  task automatic send_random_frame();
    int kind;
    int r;
    int n;
    int zero_pct;
    kind     = $urandom_range(99);
    zero_pct = ($urandom_range(3) == 0) ? 0 : 20;
    r        = $urandom_range(99);
    if (r < 80) n = $urandom_range(16);
    else if (r < 96) n = $urandom_range(64, 17);
    else n = $urandom_range(520, 250);
    fill_payload(n, zero_pct);
    if (kind < 60) begin
      append_crc();
      encode_link();
    end else if (kind < 75) begin
      append_crc();
      raw_q[$urandom_range(raw_q.size() - 1)] ^= 8'($urandom_range(255, 1));
      encode_link();
    end else if (kind < 85) begin
      append_crc();
      encode_link();
      // Cut the last block short, or open a block that never gets its bytes
      if (link_q.size() > 1 && $urandom_range(1) == 1) link_q.pop_back();
      else link_q.push_back(8'($urandom_range(255, 2)));
    end else if (kind < 95) begin
      link_q.delete();
      repeat (n + 1) link_q.push_back(8'($urandom_range(255)));
    end else begin
      link_q.delete();
    end
    send_link();
  endtask

  initial begin
    int phase_end;
    int next_cfg_at;
    int cfg_writes;

    repeat (ResetCycles) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed frames at the reset threshold of 8 bytes.
    // Empty frame: too short with length zero.
    link_q.delete();
    send_link();
    // Two plain bytes in one block: too short.
    link_q = {8'h03, 8'h11, 8'h22};
    send_link();
    // Block announces four bytes but the delimiter comes after one.
    link_q = {8'h05, 8'hAA};
    send_link();
    // All-ones byte, then an implied zero from a one-code block.
    link_q = {8'h02, 8'hFF, EmptyCode};
    send_link();
    // Exactly eight decoded bytes with a good CRC.
    raw_q = {8'h00, 8'hFF, 8'h80, 8'h01};
    append_crc();
    encode_link();
    send_link();

    // Random frames in three idling phases, changing the threshold as they go
    link_bytes_sent = 0;
    next_cfg_at     = 0;
    cfg_writes      = 0;
    for (int p = 0; p < 3; p++) begin
      if (p == 0) begin
        tx_idle_pct = 6;
        rx_idle_pct = 56;
      end else if (p == 1) begin
        tx_idle_pct = 56;
        rx_idle_pct = 6;
      end else begin
        tx_idle_pct = 0;
        rx_idle_pct = 0;
      end
      phase_end = link_bytes_sent + PhaseBytes;
      while (link_bytes_sent < phase_end) begin
        if (link_bytes_sent >= next_cfg_at) begin
          write_min_len(pick_min_len(cfg_writes));
          cfg_writes++;
          next_cfg_at = link_bytes_sent + CfgSegmentBytes;
        end
        send_random_frame();
      end
    end

    // Drain: wait for every result, then idle to catch strays
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (DrainCycles) @(negedge clk);
    if (fail_count == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end

endmodule
